/* hw/rtl/trickle_interval_timer_macros.svh */
// Assertion macros shared by the trickle interval timer RTL.
`ifndef TRICKLE_INTERVAL_TIMER_MACROS_SVH
`define TRICKLE_INTERVAL_TIMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRKL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trickle timer check failed");

// Consequent must hold in the cycle after the antecedent.
`define TRKL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trickle timer check failed");

`endif

/* hw/rtl/trkl_pkg.sv */
// Shared constants, codes and types of the trickle interval timer.
package trkl_pkg;

   // random source and datapath widths
   localparam int RANDOM_BITS = 16;
   localparam int RND_IN_W    = 16;
   localparam int RND_W       = (RANDOM_BITS < RND_IN_W) ? RANDOM_BITS : RND_IN_W;
   localparam int TICK_W      = 32;
   localparam int HALF_W      = TICK_W - 1;
   localparam int TPS_W       = 11;
   localparam int EXP_W       = 5;
   localparam int MAXD_W      = 4;
   localparam int CNT_W       = 8;
   localparam int PROD_W      = HALF_W + RND_W;
   localparam int TDV_W       = TPS_W + (2 ** EXP_W) - 1;
   localparam int DIVD_W      = (PROD_W > TDV_W) ? PROD_W : TDV_W;
   localparam int MS_PER_SEC  = 1000;
   localparam int DVS_W       = (RANDOM_BITS > 10) ? RANDOM_BITS : 10;
   localparam int STEP_W      = $clog2(DIVD_W + 1);
   localparam int MSTEP_W     = $clog2(RND_W + 1);

   localparam logic [DVS_W-1:0] MS_DIVISOR = DVS_W'(MS_PER_SEC);
   localparam logic [DVS_W-1:0] RAND_MAX   = DVS_W'((64'd1 << RANDOM_BITS) - 64'd1);
   localparam logic [EXP_W-1:0] EXP_MAX    = '1;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_EXP = 2'd0,
      CSR_MAX_DBL = 2'd1,
      CSR_RED_LIM = 2'd2,
      CSR_TPS     = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_HEARD = 2'd1,
      CMD_RESET = 2'd2,
      CMD_START = 2'd3
   } cmd_type;

   // handshake status of a multi-cycle unit
   typedef struct packed {
      logic busy;
      logic done;
   } trkl_stat_type;

   // one response item
   typedef struct packed {
      logic             send;
      logic             supp;
      logic             started;
      logic [EXP_W-1:0] exp;
      logic [CNT_W-1:0] heard;
   } trkl_rsp_type;

endpackage

/* hw/rtl/trkl_sdiv.sv */
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module trkl_sdiv
   import trkl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]  divisor,
   output logic [TICK_W-1:0] quotient,
   output logic              overflow,
   output trkl_stat_type     stat
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [TICK_W-1:0] quo_ff, quo_in;
   logic              ovf_ff, ovf_in;

   logic [DVS_W:0]    trial;
   logic              fits;

   // trial subtract of the divisor from the shifted remainder
   assign trial = {rem_ff, dvd_ff[DIVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DIVD_W-2:0], 1'b0};
         rem_in  = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_in  = {quo_ff[TICK_W-2:0], fits};
         // high quotient bits that leave the register mark overflow
         ovf_in  = ovf_ff | quo_ff[TICK_W-1];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      ovf_ff  <= ovf_in;
   end

   assign quotient  = quo_ff;
   assign overflow  = ovf_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* hw/rtl/trkl_calc.sv */
// Interval setup: ticks from 2^exp ms, fire point and remainder, computed serially.
`include "trickle_interval_timer_macros.svh"

module trkl_calc
   import trkl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [EXP_W-1:0]    exp,
   input  logic [TPS_W-1:0]    tps,
   input  logic [RND_IN_W-1:0] rnd,
   output logic [TICK_W-1:0]   point,
   output logic [TICK_W-1:0]   rest,
   output trkl_stat_type       stat
);

   typedef enum logic [4:0] {
      C_IDLE = 5'b00001,
      C_TDIV = 5'b00010,
      C_MUL  = 5'b00100,
      C_PDIV = 5'b01000,
      C_SUM  = 5'b10000
   } calc_state_type;

   calc_state_type     state_ff, state_in;
   logic               done_ff, done_in;
   logic [TICK_W-1:0]  ticks_ff, ticks_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [MSTEP_W-1:0] mstep_ff, mstep_in;
   logic [TICK_W-1:0]  point_ff, point_in;
   logic [TICK_W-1:0]  rest_ff, rest_in;

   logic               div_start;
   logic [DIVD_W-1:0]  div_dividend;
   logic [DVS_W-1:0]   div_divisor;
   logic [TICK_W-1:0]  div_quo;
   logic               div_ovf;
   trkl_stat_type      div_stat;

   logic [HALF_W-1:0]  half;
   logic [HALF_W-1:0]  addend;
   logic [HALF_W:0]    sum;

   // shift-add multiply of half interval by the random value, LSB first
   assign half   = ticks_ff[TICK_W-1:1];
   assign addend = acc_ff[0] ? half : '0;
   assign sum    = {1'b0, acc_ff[PROD_W-1:RND_W]} + {1'b0, addend};

   always_comb begin
      state_in     = state_ff;
      done_in      = 1'b0;
      ticks_in     = ticks_ff;
      acc_in       = acc_ff;
      mstep_in     = mstep_ff;
      point_in     = point_ff;
      rest_in      = rest_ff;
      div_start    = 1'b0;
      div_dividend = DIVD_W'(tps) << exp;
      div_divisor  = MS_DIVISOR;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               div_start = 1'b1;
               acc_in    = PROD_W'(rnd[RND_W-1:0]);
               state_in  = C_TDIV;
            end
         end
         C_TDIV: begin
            // ms * tps / 1000, saturated to the tick width
            if (div_stat.done) begin
               ticks_in = div_ovf ? '1 : div_quo;
               mstep_in = '0;
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            acc_in   = {sum, acc_ff[RND_W-1:1]};
            mstep_in = mstep_ff + MSTEP_W'(1);
            if (mstep_ff == MSTEP_W'(RND_W - 1)) begin
               div_start    = 1'b1;
               div_dividend = DIVD_W'(acc_in);
               div_divisor  = RAND_MAX;
               state_in     = C_PDIV;
            end
         end
         C_PDIV: begin
            if (div_stat.done) begin
               point_in = {1'b0, half} + div_quo;
               state_in = C_SUM;
            end
         end
         C_SUM: begin
            rest_in  = ticks_ff - point_ff;
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ticks_ff <= ticks_in;
      acc_ff   <= acc_in;
      mstep_ff <= mstep_in;
      point_ff <= point_in;
      rest_ff  <= rest_in;
   end

   // shared divider for both the ms conversion and the random scaling
   trkl_sdiv u_sdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .overflow (div_ovf),
      .stat     (div_stat)
   );

   assign point     = point_ff;
   assign rest      = rest_ff;
   assign stat.busy = (state_ff != C_IDLE);
   assign stat.done = done_ff;

   // divider finishes only while a division step is awaited
   `TRKL_ASSERT_NOW(a_div_done_state, div_stat.done, state_ff == C_TDIV || state_ff == C_PDIV)
   // while waiting on a division the divider is running or finishing
   `TRKL_ASSERT_NOW(a_div_running, state_ff == C_TDIV || state_ff == C_PDIV,
                    div_stat.busy || div_stat.done)
   // the final subtract step reports done and returns to idle
   `TRKL_ASSERT_NEXT(a_sum_done, state_ff == C_SUM, done_ff && state_ff == C_IDLE)

endmodule

/* hw/rtl/trickle_interval_timer.sv */
// Trickle interval timer top level: command handling, timer state and response register.
//
//  channel | ports                                        | direction | accepted when
//  --------+----------------------------------------------+-----------+----------------------
//  request | req_command .. req_link_local_ready          | in        | req_valid & req_ready
//  response| rsp_send_request .. rsp_heard_count          | out       | rsp_valid & rsp_ready
//  config  | csr_index, csr_write_data                    | in        | csr_write_enable
//
// Tick, heard and non-starting requests are accepted, then load the response.
// A request that starts an interval also runs two bit-serial divisions through one
// shared divider and a serial multiply before its response is loaded.
// Reset clears the timer state but not the response data, and loads the register defaults; no clearing pass.
// A new request is taken while an earlier response still waits; a stalled response
// holds the next request's result in a staging register until the output frees.
`include "trickle_interval_timer_macros.svh"

module trickle_interval_timer
   import trkl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_command,
   input  logic [RND_IN_W-1:0]   req_random_value,
   input  logic                  req_link_local_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_send_request,
   output logic                  rsp_suppressed,
   output logic                  rsp_interval_started,
   output logic [EXP_W-1:0]      rsp_current_exp,
   output logic [CNT_W-1:0]      rsp_heard_count,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_WAIT = 3'b100
   } top_state_type;

   // configuration registers
   logic [EXP_W-1:0]  min_exp_ff, min_exp_in;
   logic [MAXD_W-1:0] max_dbl_ff, max_dbl_in;
   logic [CNT_W-1:0]  red_lim_ff, red_lim_in;
   logic [TPS_W-1:0]  tps_ff, tps_in;

   // timer state
   top_state_type     state_ff, state_in;
   logic [EXP_W-1:0]  exp_ff, exp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pend_ff, pend_in;
   logic [TICK_W-1:0] ticks_left_ff, ticks_left_in;
   logic [TICK_W-1:0] rest_ff, rest_in;
   logic              link_ff, link_in;
   logic              armed_ff, armed_in;
   trkl_rsp_type      res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   trkl_rsp_type      rsp_ff, rsp_in;

   logic              accept;
   logic              need_start;
   logic              can_grow;
   logic              send;
   logic              supp;
   cmd_type           cmd;
   logic [TICK_W-1:0] calc_point;
   logic [TICK_W-1:0] calc_rest;
   trkl_stat_type     calc_stat;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);
   assign can_grow  = (exp_ff != EXP_MAX) &&
                      ({1'b0, exp_ff} < ({1'b0, min_exp_ff} + {2'b0, max_dbl_ff}));

   // configuration writes
   always_comb begin
      min_exp_in = min_exp_ff;
      max_dbl_in = max_dbl_ff;
      red_lim_in = red_lim_ff;
      tps_in     = tps_ff;
      if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MIN_EXP: min_exp_in = csr_write_data[EXP_W-1:0];
            CSR_MAX_DBL: max_dbl_in = csr_write_data[MAXD_W-1:0];
            CSR_RED_LIM: red_lim_in = csr_write_data[CNT_W-1:0];
            CSR_TPS:     tps_in     = csr_write_data[TPS_W-1:0];
            default:     ;
         endcase
      end
   end

   // request handling and sequencing
   always_comb begin
      state_in      = state_ff;
      exp_in        = exp_ff;
      count_in      = count_ff;
      pend_in       = pend_ff;
      ticks_left_in = ticks_left_ff;
      rest_in       = rest_ff;
      link_in       = link_ff;
      armed_in      = armed_ff;
      res_in        = res_ff;
      need_start    = 1'b0;
      send          = 1'b0;
      supp          = 1'b0;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_TICK: begin
                     if (armed_ff) begin
                        if (ticks_left_ff > TICK_W'(1)) begin
                           ticks_left_in = ticks_left_ff - TICK_W'(1);
                        end else if (!link_ff && !req_link_local_ready) begin
                           // link not up yet: retry one second later
                           ticks_left_in = TICK_W'(tps_ff);
                        end else begin
                           link_in = 1'b1;
                           if (pend_ff) begin
                              if (red_lim_ff != '0 && count_ff < red_lim_ff) begin
                                 send = 1'b1;
                              end else begin
                                 supp = 1'b1;
                              end
                              pend_in       = 1'b0;
                              ticks_left_in = rest_ff;
                           end else begin
                              if (can_grow) begin
                                 exp_in = exp_ff + EXP_W'(1);
                              end
                              need_start = 1'b1;
                           end
                        end
                     end
                  end
                  CMD_HEARD: begin
                     if (count_ff != '1) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_RESET: begin
                     if (exp_ff > min_exp_ff) begin
                        exp_in     = min_exp_ff;
                        need_start = 1'b1;
                     end
                  end
                  CMD_START: begin
                     exp_in     = min_exp_ff;
                     need_start = 1'b1;
                  end
                  default: ;
               endcase
               if (need_start) begin
                  pend_in  = 1'b1;
                  count_in = '0;
                  armed_in = 1'b1;
                  state_in = S_CALC;
               end else begin
                  state_in = S_WAIT;
               end
               res_in.send    = send;
               res_in.supp    = supp;
               res_in.started = need_start;
               res_in.exp     = exp_in;
               res_in.heard   = count_in;
            end
         end
         S_CALC: begin
            if (calc_stat.done) begin
               ticks_left_in = calc_point;
               rest_in       = calc_rest;
               state_in      = S_WAIT;
            end
         end
         S_WAIT: begin
            // move the staged result into the output register once it frees
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_exp_ff    <= EXP_W'(12);
         max_dbl_ff    <= MAXD_W'(8);
         red_lim_ff    <= CNT_W'(10);
         tps_ff        <= TPS_W'(128);
         state_ff      <= S_IDLE;
         exp_ff        <= '0;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         ticks_left_ff <= '0;
         rest_ff       <= '0;
         link_ff       <= 1'b0;
         armed_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         min_exp_ff    <= min_exp_in;
         max_dbl_ff    <= max_dbl_in;
         red_lim_ff    <= red_lim_in;
         tps_ff        <= tps_in;
         state_ff      <= state_in;
         exp_ff        <= exp_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         ticks_left_ff <= ticks_left_in;
         rest_ff       <= rest_in;
         link_ff       <= link_in;
         armed_ff      <= armed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   // interval setup unit
   trkl_calc u_calc (
      .clock (clock),
      .reset (reset),
      .start (accept && need_start),
      .exp   (exp_in),
      .tps   (tps_ff),
      .rnd   (req_random_value),
      .point (calc_point),
      .rest  (calc_rest),
      .stat  (calc_stat)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_send_request     = rsp_ff.send;
   assign rsp_suppressed       = rsp_ff.supp;
   assign rsp_interval_started = rsp_ff.started;
   assign rsp_current_exp      = rsp_ff.exp;
   assign rsp_heard_count      = rsp_ff.heard;

   // no request is taken while an interval is still being set up
   `TRKL_ASSERT_NOW(a_idle_no_calc, state_ff == S_IDLE, !calc_stat.busy)
   // a starting request launches the setup unit
   `TRKL_ASSERT_NEXT(a_start_calc, accept && need_start, state_ff == S_CALC && calc_stat.busy)
   // a new interval always reports a cleared heard count
   `TRKL_ASSERT_NOW(a_start_clears, rsp_valid && rsp_interval_started, rsp_heard_count == '0)

endmodule

/* dv/tb.sv */
// Self-checking testbench for the trickle interval timer: directed and random request streams.
module tb;
   import trkl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_command = CMD_TICK;
   logic [RND_IN_W-1:0]   req_random_value = '0;
   logic                  req_link_local_ready = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_send_request;
   logic                  rsp_suppressed;
   logic                  rsp_interval_started;
   logic [EXP_W-1:0]      rsp_current_exp;
   logic [CNT_W-1:0]      rsp_heard_count;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MIN_EXP;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   trickle_interval_timer u_dut (.*);

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // timer registers as the predictor sees them
   logic [EXP_W-1:0]  cfg_min_exp;
   logic [MAXD_W-1:0] cfg_max_dbl;
   logic [CNT_W-1:0]  cfg_red_lim;
   logic [TPS_W-1:0]  cfg_tps;

   // predicted timer state
   logic [EXP_W-1:0]  tm_exp;
   logic [CNT_W-1:0]  tm_heard;
   logic              tm_pending;
   logic [TICK_W-1:0] tm_ticks_left;
   logic [TICK_W-1:0] tm_rest;
   logic              tm_link_ok;
   logic              tm_armed;

   trkl_rsp_type predicted_rsps[$];

   logic quiet = 1'b0;       // no idling on either side while set
   int   mismatches = 0;
   int   stall_cycles = 0;
   int   n_requests = 0;
   int   n_responses = 0;
   int   n_sends = 0;
   int   n_suppressed = 0;
   int   n_starts = 0;
   int   n_settings = 0;

   // ---------------------------------------------------------------- predictor

   // new interval: 2^exp ms in ticks, fire point drawn in [I/2, I]
   function automatic void draw_interval(input logic [RND_IN_W-1:0] rnd);
      logic [63:0] rmax, ticks, half, point, r;
      rmax  = (64'd1 << RANDOM_BITS) - 64'd1;
      ticks = ((64'd1 << tm_exp) * 64'(cfg_tps)) / 64'(MS_PER_SEC);
      if (ticks > 64'hFFFF_FFFF) begin
         ticks = 64'hFFFF_FFFF;
      end
      r     = 64'(rnd) & rmax;
      half  = ticks / 64'd2;
      point = half + (half * r) / rmax;
      tm_rest       = TICK_W'(ticks - point);
      tm_ticks_left = TICK_W'(point);
      tm_pending    = 1'b1;
      tm_heard      = '0;
      tm_armed      = 1'b1;
   endfunction

   // advance the timer by one request and return the response it gives
   function automatic trkl_rsp_type trickle_advance(input cmd_type cmd,
                                                    input logic [RND_IN_W-1:0] rnd,
                                                    input logic link);
      trkl_rsp_type res;
      logic         go;
      res = '0;
      go  = 1'b1;
      case (cmd)
         CMD_TICK: begin
            if (tm_armed) begin
               if (tm_ticks_left > 1) begin
                  tm_ticks_left--;
               end else begin
                  // fire before the link is up: retry a second later
                  if (!tm_link_ok) begin
                     if (link) begin
                        tm_link_ok = 1'b1;
                     end else begin
                        tm_ticks_left = TICK_W'(cfg_tps);
                        go = 1'b0;
                     end
                  end
                  if (go && tm_pending) begin
                     if (cfg_red_lim != 0 && tm_heard < cfg_red_lim) res.send = 1'b1;
                     else res.supp = 1'b1;
                     tm_pending    = 1'b0;
                     tm_ticks_left = tm_rest;
                  end else if (go) begin
                     // interval end: double up to the ceiling
                     if (tm_exp < EXP_MAX &&
                         32'(tm_exp) < 32'(cfg_min_exp) + 32'(cfg_max_dbl)) begin
                        tm_exp++;
                     end
                     draw_interval(rnd);
                     res.started = 1'b1;
                  end
               end
            end
         end
         CMD_HEARD: begin
            if (tm_heard < 8'd255) tm_heard++;
         end
         CMD_RESET: begin
            if (tm_exp > cfg_min_exp) begin
               tm_exp = cfg_min_exp;
               draw_interval(rnd);
               res.started = 1'b1;
            end
         end
         default: begin
            tm_exp = cfg_min_exp;
            draw_interval(rnd);
            res.started = 1'b1;
         end
      endcase
      res.exp   = tm_exp;
      res.heard = tm_heard;
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers

   // one request; returns right after the edge that accepted it
   task automatic send_request(input cmd_type cmd, input logic [RND_IN_W-1:0] rnd,
                               input logic link);
      trkl_rsp_type want;
      while (!quiet && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_command          <= cmd;
      req_random_value     <= rnd;
      req_link_local_ready <= link;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = trickle_advance(cmd, rnd, link);
      predicted_rsps.push_back(want);
      n_requests++;
      n_sends      += int'(want.send);
      n_suppressed += int'(want.supp);
      n_starts     += int'(want.started);
   endtask

   // sender holds off until every predicted response has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_MIN_EXP: cfg_min_exp = data[EXP_W-1:0];
         CSR_MAX_DBL: cfg_max_dbl = data[MAXD_W-1:0];
         CSR_RED_LIM: cfg_red_lim = data[CNT_W-1:0];
         default:     cfg_tps     = data[TPS_W-1:0];
      endcase
   endtask

   // only called while the timer is idle
   task automatic apply_config(input int min_exp, input int max_dbl,
                               input int red_lim, input int tps);
      write_reg(CSR_MIN_EXP, CSR_DATA_W'(min_exp));
      write_reg(CSR_MAX_DBL, CSR_DATA_W'(max_dbl));
      write_reg(CSR_RED_LIM, CSR_DATA_W'(red_lim));
      write_reg(CSR_TPS, CSR_DATA_W'(tps));
      csr_write_enable <= 1'b0;
      @(posedge clock);
      n_settings++;
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 38);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 25) begin
         $display("response %0d: %s got %0h expected %0h", n_responses, what, got, want);
      end
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      trkl_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_rsps.size() == 0) begin
            report_mismatch("unexpected response", 32'd0, 32'd0);
         end else begin
            want = predicted_rsps.pop_front();
            if (rsp_send_request !== want.send)
               report_mismatch("send_request", 32'(rsp_send_request), 32'(want.send));
            if (rsp_suppressed !== want.supp)
               report_mismatch("suppressed", 32'(rsp_suppressed), 32'(want.supp));
            if (rsp_interval_started !== want.started)
               report_mismatch("interval_started", 32'(rsp_interval_started),
                               32'(want.started));
            if (rsp_current_exp !== want.exp)
               report_mismatch("current_exp", 32'(rsp_current_exp), 32'(want.exp));
            if (rsp_heard_count !== want.heard)
               report_mismatch("heard_count", 32'(rsp_heard_count), 32'(want.heard));
         end
         n_responses++;
      end
   end

   // watchdog: no traffic on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", stall_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests

   // idle commands, retries before the link is up, suppression, doubling and ceilings
   task automatic test_directed();
      // zero ticks per second: every interval is zero ticks long
      apply_config(0, 3, 2, 0);
      send_request(CMD_TICK, 16'h0000, 1'b1);   // idle tick
      send_request(CMD_HEARD, 16'hFFFF, 1'b0);  // heard while idle
      send_request(CMD_RESET, 16'h1234, 1'b1);  // exp not above min: ignored
      send_request(CMD_START, 16'hFFFF, 1'b0);
      send_request(CMD_TICK, 16'h0000, 1'b0);   // link down: retry
      send_request(CMD_TICK, 16'h0000, 1'b0);   // retry of zero fires again
      send_request(CMD_HEARD, 16'h0000, 1'b0);
      send_request(CMD_HEARD, 16'h0000, 1'b0);
      send_request(CMD_TICK, 16'h0000, 1'b1);   // link up, count at limit: suppressed
      send_request(CMD_TICK, 16'h0000, 1'b1);   // interval end, exp 1
      send_request(CMD_TICK, 16'hAAAA, 1'b0);   // send
      for (int i = 0; i < 5; i++) begin
         send_request(CMD_TICK, 16'hFFFF, 1'b0); // doubling up to min + doublings
      end
      send_request(CMD_RESET, 16'h5555, 1'b1);
      send_request(CMD_START, 16'h8000, 1'b1);
      wait_drain();

      // exponent pinned at 31, zero redundancy limit always suppresses
      apply_config(31, 15, 0, 0);
      send_request(CMD_START, 16'hFFFF, 1'b1);
      send_request(CMD_TICK, 16'h0001, 1'b1);
      send_request(CMD_TICK, 16'hFFFE, 1'b1);
      send_request(CMD_RESET, 16'h7FFF, 1'b0);
      send_request(CMD_HEARD, 16'h0000, 1'b0);
      wait_drain();

      // longest interval saturates the tick count
      apply_config(31, 15, 255, 2047);
      send_request(CMD_START, 16'hFFFF, 1'b1);
      send_request(CMD_TICK, 16'h0000, 1'b1);
      send_request(CMD_HEARD, 16'h0000, 1'b0);
      wait_drain();
   endtask

   // heard counter saturates; a full count suppresses even the widest limit
   task automatic test_heard_saturation();
      apply_config(3, 2, 255, 1000);
      send_request(CMD_START, 16'($urandom_range(0, 65535)), 1'b1);
      for (int i = 0; i < 300; i++) begin
         send_request(CMD_HEARD, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
      for (int i = 0; i < 20; i++) begin
         send_request(CMD_TICK, 16'($urandom_range(0, 65535)), 1'b1);
      end
      wait_drain();
   endtask

   function automatic cmd_type pick_command();
      int w;
      w = $urandom_range(0, 99);
      if (w < 58) return CMD_TICK;
      if (w < 80) return CMD_HEARD;
      if (w < 90) return CMD_RESET;
      return CMD_START;
   endfunction

   function automatic logic [RND_IN_W-1:0] pick_random();
      int w;
      w = $urandom_range(0, 9);
      if (w == 0) return '0;
      if (w == 1) return '1;
      return RND_IN_W'($urandom_range(0, 65535));
   endfunction

   // random command stream under one setting, with one full hold-off on the way
   task automatic run_random_phase(input int count, input logic quiet_phase);
      int      hold_at;
      int      burst;
      cmd_type cmd;
      quiet   = quiet_phase;
      hold_at = $urandom_range(count / 4, 3 * count / 4);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) wait_drain();
         cmd = pick_command();
         // heard bursts that straddle small redundancy limits
         if (cmd == CMD_HEARD && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, (cfg_red_lim > 8'd12) ? 14 : int'(cfg_red_lim) + 2);
            for (int j = 0; j < burst; j++) begin
               send_request(CMD_HEARD, pick_random(), 1'($urandom_range(0, 1)));
            end
         end
         send_request(cmd, pick_random(), 1'($urandom_range(0, 3) != 0));
      end
      wait_drain();
      quiet = 1'b0;
   endtask

   task automatic test_random();
      apply_config(0, 0, 1, 1000);
      run_random_phase(150, 1'b0);
      apply_config(2, 11, 255, 1024);
      run_random_phase(150, 1'b1);
      apply_config(0, 5, 0, 500);
      run_random_phase(150, 1'b0);
      apply_config(10, 11, 3, 1);
      run_random_phase(150, 1'b0);
      for (int p = 0; p < 4; p++) begin
         apply_config($urandom_range(0, 6), $urandom_range(0, 11), $urandom_range(0, 12),
                      ($urandom_range(0, 1) != 0) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 1024));
         run_random_phase(150, 1'b0);
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      // predictor at reset
      cfg_min_exp   = 5'd12;
      cfg_max_dbl   = 4'd8;
      cfg_red_lim   = 8'd10;
      cfg_tps       = 11'd128;
      tm_exp        = '0;
      tm_heard      = '0;
      tm_pending    = 1'b0;
      tm_ticks_left = '0;
      tm_rest       = '0;
      tm_link_ok    = 1'b0;
      tm_armed      = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_heard_saturation();
      test_random();

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests under %0d register settings, %0d responses checked",
               n_requests, n_settings, n_responses);
      $display("Saw %0d sends, %0d suppressed fires, %0d interval starts",
               n_sends, n_suppressed, n_starts);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
